// File: rtl/bpgc_pkg.sv
// Package: shared widths, register map, event codes and bundle types.
`timescale 1ns / 1ps
package bpgc_pkg;

  localparam int unsigned NumSwitches = 3;
  localparam int unsigned CountW      = 2;
  localparam int unsigned TimerW      = 8;
  localparam int unsigned WindowW     = 6;
  localparam int unsigned AddrW       = 3;
  localparam int unsigned DataW       = 32;

  localparam logic [TimerW-1:0]  LongTicksRst   = 8'd200;
  localparam logic [WindowW-1:0] WindowTicksRst = 6'd50;
  localparam logic [CountW-1:0]  CountMax       = 2'd3;

  // register index taken from paddr[2]
  localparam logic RegLongTicks   = 1'b0;
  localparam logic RegWindowTicks = 1'b1;

  typedef enum logic [1:0] {
    EvNone   = 2'd0,
    EvSingle = 2'd1,
    EvDouble = 2'd2,
    EvLong   = 2'd3
  } event_e;

  typedef struct packed {
    logic [TimerW-1:0]  long_ticks;
    logic [WindowW-1:0] window_ticks;
  } cfg_t;

  typedef struct packed {
    logic now_level;
    logic any_changed;
    logic active;
  } sw_ctrl_t;

  typedef struct packed {
    event_e ev;
    logic   wake;
  } sw_stat_t;

  typedef struct packed {
    logic [1:0] left_event;
    logic [1:0] right_event;
    logic [1:0] encoder_event;
    logic [2:0] wake_request;
    logic       antenna_front;
    logic       antenna_back;
    logic       shaft_pressed;
  } result_t;

endpackage

// File: rtl/bpgc_if.sv
// Interfaces: valid/ready channels for tick items and result items.
`timescale 1ns / 1ps
interface bpgc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] switch_levels;
  logic       indicator_active;

  modport source (output valid, output switch_levels, output indicator_active, input ready);
  modport sink   (input valid, input switch_levels, input indicator_active, output ready);
endinterface

interface bpgc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] left_event;
  logic [1:0] right_event;
  logic [1:0] encoder_event;
  logic [2:0] wake_request;
  logic       antenna_front;
  logic       antenna_back;
  logic       shaft_pressed;

  modport source (output valid, output left_event, output right_event, output encoder_event,
                  output wake_request, output antenna_front, output antenna_back,
                  output shaft_pressed, input ready);
  modport sink   (input valid, input left_event, input right_event, input encoder_event,
                  input wake_request, input antenna_front, input antenna_back,
                  input shaft_pressed, output ready);
endinterface

// File: rtl/bpgc_switch.sv
// Per-switch press tracker: level history, press count, hold timer and window.
`timescale 1ns / 1ps
module bpgc_switch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  bpgc_pkg::cfg_t     cfg_i,
  input  bpgc_pkg::sw_ctrl_t ctrl_i,
  output logic               prev_o,
  output bpgc_pkg::sw_stat_t stat_o
);
  import bpgc_pkg::*;

  logic               prev_q, prev_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [TimerW-1:0]  timer_q, timer_d;
  logic [WindowW-1:0] cd_q, cd_d;
  logic               rel_q, rel_d;
  logic               len_q, len_d;
  logic [TimerW:0]    hold_next;
  logic [WindowW-1:0] cd_dec;
  event_e             ev;
  logic               wake;

  assign hold_next = {1'b0, timer_q} + {{TimerW{1'b0}}, 1'b1};
  assign cd_dec    = cd_q - {{(WindowW-1){1'b0}}, 1'b1};

  always_comb begin
    prev_d  = ctrl_i.now_level;
    cnt_d   = cnt_q;
    timer_d = timer_q;
    cd_d    = cd_q;
    rel_d   = rel_q;
    len_d   = len_q;
    ev      = EvNone;
    wake    = 1'b0;

    if (ctrl_i.any_changed) begin
      if (ctrl_i.now_level != prev_q) begin
        if (prev_q) begin
          // press
          if (ctrl_i.active) begin
            if (cnt_q != CountMax) cnt_d = cnt_q + {{(CountW-1){1'b0}}, 1'b1};
            rel_d = 1'b0;
          end else begin
            len_d = 1'b0;
          end
        end else begin
          // release
          if (!ctrl_i.active) begin
            wake = 1'b1;
          end else begin
            timer_d = '0;
            rel_d   = 1'b1;
          end
          len_d = 1'b1;
        end
      end
    end else if (!prev_q && len_q) begin
      if (hold_next >= {1'b0, cfg_i.long_ticks}) begin
        ev      = EvLong;
        timer_d = '0;
        cnt_d   = '0;
        len_d   = 1'b0;
      end else begin
        timer_d = hold_next[TimerW-1:0];
      end
    end

    // multi-press window runs on the count left by the edge logic above
    if (cd_q != '0) begin
      cd_d = cd_dec;
      if (cd_dec == '0) begin
        if ((cnt_d == 2'd1 || cnt_d == 2'd2) && ev == EvNone) ev = event_e'(cnt_d);
        cnt_d = '0;
      end
    end else if (cnt_d == 2'd1 && rel_d) begin
      cd_d = cfg_i.window_ticks;
    end else if (cnt_d == CountMax) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b1;
      cnt_q   <= '0;
      timer_q <= '0;
      cd_q    <= '0;
      rel_q   <= 1'b0;
      len_q   <= 1'b1;
    end else if (adv_i) begin
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      timer_q <= timer_d;
      cd_q    <= cd_d;
      rel_q   <= rel_d;
      len_q   <= len_d;
    end
  end

  assign prev_o      = prev_q;
  assign stat_o.ev   = ev;
  assign stat_o.wake = wake;

endmodule

// File: rtl/button_press_gesture_classifier.sv
// Top level: gesture classifier with APB config registers and a registered result.
//
//   port      dir  kind       carries
//   in_i      in   valid/rdy  switch_levels[2:0], indicator_active (one 50 ms tick)
//   out_o     out  valid/rdy  three 2-bit events, wake mask, antenna and shaft levels
//   APB       in   apb write  long_press_ticks @0x0, multi_press_window_ticks @0x4
//
// One tick per clock while out_o is not stalled: state advances at the input transfer
// and the result is registered, so it appears in the following cycle. The single result
// register sets the rate: in_i.ready is high whenever it is empty or being drained.
// Reset: all switches open, counters cleared, config back to 200 / 50 ticks.
// A stalled out_o holds the result and back-pressures in_i.
`timescale 1ns / 1ps
module button_press_gesture_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpgc_pkg::AddrW-1:0]   paddr,
  input  logic [bpgc_pkg::DataW-1:0]   pwdata,
  output logic [bpgc_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  bpgc_in_if.sink                      in_i,
  bpgc_out_if.source                   out_o
);
  import bpgc_pkg::*;

  cfg_t     cfg_q;
  result_t  res_q, res_d;
  logic     out_valid_q;
  logic     accept;
  logic     any_changed;
  logic [NumSwitches-1:0] prev;
  sw_stat_t stat [NumSwitches];

  // config registers
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_ticks   <= LongTicksRst;
      cfg_q.window_ticks <= WindowTicksRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        RegLongTicks:   cfg_q.long_ticks   <= pwdata[TimerW-1:0];
        RegWindowTicks: cfg_q.window_ticks <= pwdata[WindowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegLongTicks:   prdata = {{(DataW-TimerW){1'b0}}, cfg_q.long_ticks};
      RegWindowTicks: prdata = {{(DataW-WindowW){1'b0}}, cfg_q.window_ticks};
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign any_changed = in_i.switch_levels != prev;

  for (genvar g = 0; g < NumSwitches; g++) begin : g_sw
    sw_ctrl_t ctrl;
    assign ctrl.now_level   = in_i.switch_levels[g];
    assign ctrl.any_changed = any_changed;
    assign ctrl.active      = in_i.indicator_active;

    bpgc_switch u_switch (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (accept),
      .cfg_i  (cfg_q),
      .ctrl_i (ctrl),
      .prev_o (prev[g]),
      .stat_o (stat[g])
    );
  end

  always_comb begin
    res_d.left_event    = stat[0].ev;
    res_d.right_event   = stat[1].ev;
    res_d.encoder_event = stat[2].ev;
    res_d.wake_request  = {stat[2].wake, stat[1].wake, stat[0].wake};
    res_d.antenna_front = !prev[0];
    res_d.antenna_back  = prev[0] && !prev[1];
    res_d.shaft_pressed = !prev[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.left_event    = res_q.left_event;
  assign out_o.right_event   = res_q.right_event;
  assign out_o.encoder_event = res_q.encoder_event;
  assign out_o.wake_request  = res_q.wake_request;
  assign out_o.antenna_front = res_q.antenna_front;
  assign out_o.antenna_back  = res_q.antenna_back;
  assign out_o.shaft_pressed = res_q.shaft_pressed;

  // checks
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_o.valid)
    else $error("no result after tick transfer");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(accept))
    else $error("result without tick transfer");

  a_antenna_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.antenna_front && out_o.antenna_back))
    else $error("both antennas selected");

  a_wake_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.indicator_active) |=> (out_o.wake_request == 3'd0))
    else $error("wake request while indicator active");

  a_wake_no_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !any_changed) |=> (out_o.wake_request == 3'd0))
    else $error("wake request without a level change");

endmodule

// File: tb/button_press_gesture_classifier_test.sv
// Testbench: directed and random switch ticks checked against a gesture predictor.
`timescale 1ns / 1ps
module button_press_gesture_classifier_test;
  import bpgc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int IdlePct    = 21;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [2:0] levels;
    logic       active;
  } tick_t;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [AddrW-1:0]    paddr   = '0;
  logic [DataW-1:0]    pwdata  = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;

  bpgc_in_if  tick_if ();
  bpgc_out_if gesture_if ();

  button_press_gesture_classifier i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (tick_if),
    .out_o   (gesture_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state and its copy of the registers
  logic [2:0]         prev_levels;
  logic [CountW-1:0]  press_cnt  [NumSwitches];
  logic [TimerW-1:0]  hold_cnt   [NumSwitches];
  logic [WindowW-1:0] window_cnt [NumSwitches];
  logic [2:0]         released;
  logic [2:0]         long_armed;
  logic [TimerW-1:0]  cfg_long;
  logic [WindowW-1:0] cfg_window;

  tick_t   pending_ticks [$];
  result_t expected_gestures [$];
  int      ticks_made = 0;
  int      mismatches = 0;
  int      cycles     = 0;
  bit      steady     = 1'b0;

  function automatic result_t classify_tick(input logic [2:0] levels, input logic active);
    logic [2:0]    last;
    logic [2:0]    wake;
    event_e        ev [NumSwitches];
    logic [TimerW:0] held;
    result_t       r;
    last = prev_levels;
    wake = '0;
    for (int i = 0; i < NumSwitches; i++) ev[i] = EvNone;
    if (levels != last) begin
      for (int i = 0; i < NumSwitches; i++) begin
        if (levels[i] != last[i]) begin
          if (last[i]) begin
            // open to closed
            if (active) begin
              if (press_cnt[i] != CountMax) press_cnt[i] = press_cnt[i] + 1'b1;
              released[i] = 1'b0;
            end else begin
              long_armed[i] = 1'b0;
            end
          end else begin
            if (active) begin
              hold_cnt[i] = '0;
              released[i] = 1'b1;
            end else begin
              wake[i] = 1'b1;
            end
            long_armed[i] = 1'b1;
          end
        end
      end
    end else begin
      for (int i = 0; i < NumSwitches; i++) begin
        if (!last[i] && long_armed[i]) begin
          held = {1'b0, hold_cnt[i]} + 1'b1;
          if (held >= {1'b0, cfg_long}) begin
            ev[i]         = EvLong;
            hold_cnt[i]   = '0;
            press_cnt[i]  = '0;
            long_armed[i] = 1'b0;
          end else begin
            hold_cnt[i] = held[TimerW-1:0];
          end
        end
      end
    end
    for (int i = 0; i < NumSwitches; i++) begin
      if (window_cnt[i] != '0) begin
        window_cnt[i] = window_cnt[i] - 1'b1;
        if (window_cnt[i] == '0) begin
          if (press_cnt[i] != '0 && press_cnt[i] != CountMax && ev[i] == EvNone)
            ev[i] = event_e'(press_cnt[i]);
          press_cnt[i] = '0;
        end
      end else if (press_cnt[i] == 2'd1 && released[i]) begin
        window_cnt[i] = cfg_window;
      end else if (press_cnt[i] == CountMax) begin
        press_cnt[i] = '0;
      end
    end
    r.left_event    = ev[0];
    r.right_event   = ev[1];
    r.encoder_event = ev[2];
    r.wake_request  = wake;
    r.antenna_front = !last[0];
    r.antenna_back  = last[0] && !last[1];
    r.shaft_pressed = !last[2];
    prev_levels = levels;
    return r;
  endfunction

  function automatic void report(input string what, input result_t want, input result_t seen);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%s: expected ev %0d/%0d/%0d wake %b ant %b%b shaft %b",
               what, want.left_event, want.right_event, want.encoder_event, want.wake_request,
               want.antenna_front, want.antenna_back, want.shaft_pressed);
      $display("%s: got      ev %0d/%0d/%0d wake %b ant %b%b shaft %b",
               what, seen.left_event, seen.right_event, seen.encoder_event, seen.wake_request,
               seen.antenna_front, seen.antenna_back, seen.shaft_pressed);
    end
  endfunction

  task automatic push_tick(input logic [2:0] levels, input logic active);
    tick_t t;
    t.levels = levels;
    t.active = active;
    pending_ticks.push_back(t);
    ticks_made++;
  endtask

  // close the masked switches for len ticks, then open everything
  task automatic press(input logic [2:0] mask, input int len, input logic active);
    repeat (len) push_tick(~mask, active);
    push_tick(3'b111, active);
  endtask

  task automatic gen_gestures(input int budget);
    int         start;
    int         kind;
    int         len;
    logic [2:0] mask;
    logic       act;
    start = ticks_made;
    while (ticks_made - start < budget) begin
      kind = $urandom_range(99);
      mask = ($urandom_range(3) == 0) ? 3'($urandom_range(1, 7)) : 3'(1 << $urandom_range(2));
      act  = ($urandom_range(9) != 0);
      if (kind < 15) begin
        repeat ($urandom_range(1, 4)) push_tick(3'($urandom), 1'($urandom));
      end else if (kind < 30) begin
        // hold past the long-press length, or a plain long-ish press when that is out of reach
        len = (cfg_long > 32) ? $urandom_range(1, 32) : int'(cfg_long) + 1 + $urandom_range(2);
        press(mask, len, act);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          press(mask, $urandom_range(1, 3), act);
          repeat ($urandom_range(0, cfg_window)) push_tick(3'b111, act);
        end
      end
      repeat ($urandom_range(0, int'(cfg_window) + 2)) push_tick(3'b111, 1'b1);
    end
  endtask

  task automatic apb_write(input logic idx, input logic [DataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [TimerW-1:0] long_ticks,
                            input logic [WindowW-1:0] window_ticks);
    apb_write(RegLongTicks, DataW'(long_ticks));
    apb_write(RegWindowTicks, DataW'(window_ticks));
    cfg_long   = long_ticks;
    cfg_window = window_ticks;
  endtask

  // wait until every tick is sent and every result is back; sampled mid-cycle so the
  // driver and monitor updates of the last edge are already visible
  task automatic settle();
    do @(negedge clk_i);
    while (pending_ticks.size() != 0 || tick_if.valid || expected_gestures.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : drive_ticks
    tick_t t;
    if (rst_ni && (!tick_if.valid || tick_if.ready)) begin
      if (pending_ticks.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
        t = pending_ticks.pop_front();
        tick_if.valid            <= 1'b1;
        tick_if.switch_levels    <= t.levels;
        tick_if.indicator_active <= t.active;
      end else begin
        tick_if.valid            <= 1'b0;
        tick_if.switch_levels    <= 3'($urandom);
        tick_if.indicator_active <= 1'($urandom);
      end
    end
  end

  always @(posedge clk_i) begin : check_gestures
    result_t seen;
    result_t want;
    if (rst_ni) begin
      if (gesture_if.valid && gesture_if.ready) begin
        seen.left_event    = gesture_if.left_event;
        seen.right_event   = gesture_if.right_event;
        seen.encoder_event = gesture_if.encoder_event;
        seen.wake_request  = gesture_if.wake_request;
        seen.antenna_front = gesture_if.antenna_front;
        seen.antenna_back  = gesture_if.antenna_back;
        seen.shaft_pressed = gesture_if.shaft_pressed;
        if (expected_gestures.size() == 0) begin
          report("unexpected result", '0, seen);
        end else begin
          want = expected_gestures.pop_front();
          if (seen !== want) report("result mismatch", want, seen);
        end
      end
      if (tick_if.valid && tick_if.ready)
        expected_gestures.push_back(classify_tick(tick_if.switch_levels,
                                                  tick_if.indicator_active));
      gesture_if.ready <= steady || $urandom_range(99) >= IdlePct;
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("button_press_gesture_classifier_test failed");
      $finish;
    end
  end

  initial begin
    tick_if.valid            = 1'b0;
    tick_if.switch_levels    = 3'b111;
    tick_if.indicator_active = 1'b0;
    gesture_if.ready         = 1'b0;
    prev_levels = 3'b111;
    released    = '0;
    long_armed  = 3'b111;
    for (int i = 0; i < NumSwitches; i++) begin
      press_cnt[i]  = '0;
      hold_cnt[i]   = '0;
      window_cnt[i] = '0;
    end
    cfg_long   = LongTicksRst;
    cfg_window = WindowTicksRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset lengths: left held into a long press, then random gestures with the reset lengths
    press(3'b001, 201, 1'b1);
    gen_gestures(10);
    settle();

    set_config(8'd2, 6'd3);
    // left single tap
    push_tick(3'b111, 1'b1); push_tick(3'b110, 1'b1); push_tick(3'b111, 1'b1);
    push_tick(3'b111, 1'b1); push_tick(3'b111, 1'b1); push_tick(3'b111, 1'b1);
    // right double tap
    push_tick(3'b101, 1'b1); push_tick(3'b111, 1'b1); push_tick(3'b101, 1'b1);
    push_tick(3'b111, 1'b1); push_tick(3'b111, 1'b1); push_tick(3'b111, 1'b1);
    push_tick(3'b111, 1'b1);
    // all switches held into a long press
    push_tick(3'b000, 1'b1); push_tick(3'b000, 1'b1); push_tick(3'b000, 1'b1);
    push_tick(3'b111, 1'b1);
    // encoder pressed three times in one window
    push_tick(3'b011, 1'b1); push_tick(3'b111, 1'b1); push_tick(3'b011, 1'b1);
    push_tick(3'b111, 1'b1); push_tick(3'b011, 1'b1);
    // indicator off: no long press, releases ask for wake
    push_tick(3'b000, 1'b0); push_tick(3'b000, 1'b0); push_tick(3'b111, 1'b0);
    settle();

    set_config(8'd4, 6'd6);
    gen_gestures(30);
    settle();

    set_config(8'd0, 6'd0);
    gen_gestures(20);
    settle();

    set_config(8'd1, 6'd1);
    gen_gestures(10);
    settle();

    steady = 1'b1;
    set_config(8'd7, 6'd12);
    gen_gestures(30);
    settle();
    steady = 1'b0;

    set_config(8'($urandom_range(1, 255)), 6'($urandom_range(1, 63)));
    gen_gestures(10);
    settle();

    if (mismatches == 0 && expected_gestures.size() == 0) begin
      $display("button_press_gesture_classifier_test passed");
    end else begin
      $display("button_press_gesture_classifier_test failed");
    end
    $finish;
  end

endmodule
